>>> src/rdsc_pkg.sv
// Shared types, constants and the digit character map for the radix digit string converter.
// No dependencies; imported by every module of the block.
package rdsc_pkg;

    localparam int VALUE_W      = 64;
    localparam int CHAR_W       = 7;
    localparam int RADIX_W      = 7;
    localparam int STORE_DEPTH  = 64;
    localparam int STORE_AW     = 6;
    localparam int CNT_W        = 7;
    localparam int BITS_PER_CYC = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;

    localparam logic [CHAR_W-1:0] CH_DIGIT   = 7'd48;
    localparam logic [CHAR_W-1:0] CH_UPPER   = 7'd65;
    localparam logic [CHAR_W-1:0] CH_LOWER   = 7'd97;
    localparam logic [CHAR_W-1:0] CH_PUNCT_A = 7'd41;
    localparam logic [CHAR_W-1:0] CH_PUNCT_B = 7'd58;
    localparam logic [CHAR_W-1:0] CH_PUNCT_C = 7'd91;
    localparam logic [CHAR_W-1:0] CH_PUNCT_D = 7'd123;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_zero;
    } t_item;

    function automatic logic [CHAR_W-1:0] char_of(input logic [CHAR_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d) inside
            [7'd0:7'd9]:   c = CH_DIGIT + d;
            [7'd10:7'd35]: c = CH_UPPER + (d - 7'd10);
            [7'd36:7'd61]: c = CH_LOWER + (d - 7'd36);
            [7'd62:7'd68]: c = CH_PUNCT_A + (d - 7'd62);
            [7'd69:7'd75]: c = CH_PUNCT_B + (d - 7'd69);
            [7'd76:7'd81]: c = CH_PUNCT_C + (d - 7'd76);
            default:       c = CH_PUNCT_D + (d - 7'd82);
        endcase
        return c;
    endfunction

endpackage

>>> src/rdsc_front.sv
// Front stage: input register, masks the number to NUM_WIDTH bits and flags zero.
// Depends on rdsc_pkg.
module rdsc_front #(
    parameter int NUM_WIDTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rdsc_pkg::VALUE_W-1:0] i_value,
    output logic                         o_push,
    output rdsc_pkg::t_item              o_item,
    input  logic                         i_full
);
    import rdsc_pkg::*;

    localparam logic [VALUE_W-1:0] MASK = {VALUE_W{1'b1}} >> (VALUE_W - NUM_WIDTH);

    logic               r_valid, n_valid;
    t_item              r_item;
    logic [VALUE_W-1:0] w_masked;
    logic               w_accept;

    assign w_masked = i_value & MASK;
    assign o_push   = r_valid && !i_full;
    assign o_ready  = !r_valid || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_item   = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.value   <= w_masked;
            r_item.is_zero <= (w_masked == '0);
        end
    end

endmodule

>>> src/rdsc_queue.sv
// Two-entry queue between the front and back stages.
// Depends on rdsc_pkg.
module rdsc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rdsc_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output rdsc_pkg::t_item o_item
);
    import rdsc_pkg::*;

    t_item       r_mem [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count, n_count;
    logic        w_push, w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

>>> src/rdsc_back.sv
// Back stage: repeated long division by the radix, eight bits a cycle, digits into a
// 64-entry store, then emission most significant first through an output register.
// Depends on rdsc_pkg.
module rdsc_back #(
    parameter int NUM_WIDTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_pop,
    input  rdsc_pkg::t_item              i_item,
    input  logic [rdsc_pkg::RADIX_W-1:0] i_radix,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [rdsc_pkg::CHAR_W-1:0]  o_tdata,
    output logic                         o_tlast
);
    import rdsc_pkg::*;

    localparam int STEPS  = (NUM_WIDTH + BITS_PER_CYC - 1) / BITS_PER_CYC;
    localparam int PAD_W  = STEPS * BITS_PER_CYC;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [PAD_W-1:0]    r_q, n_q;
    logic [RADIX_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [STORE_AW-1:0] r_idx, n_idx;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_data, n_out_data;
    logic                r_out_last, n_out_last;

    logic [CHAR_W-1:0]   r_store [STORE_DEPTH];
    logic [CHAR_W-1:0]   r_rd_data;

    logic [PAD_W-1:0]    w_q;
    logic [RADIX_W-1:0]  w_rem;
    logic [RADIX_W:0]    w_t;
    logic                w_ge;
    logic                w_we;
    logic [STORE_AW-1:0] w_waddr;
    logic [CHAR_W-1:0]   w_wdata;

    // restoring division, one quotient bit per step
    always_comb begin
        w_q   = r_q;
        w_rem = r_rem;
        w_t   = '0;
        w_ge  = 1'b0;
        for (int j = 0; j < BITS_PER_CYC; j++) begin
            w_t  = {w_rem, w_q[PAD_W-1]};
            w_ge = (w_t >= {1'b0, i_radix});
            if (w_ge) begin
                w_t = w_t - {1'b0, i_radix};
            end
            w_rem = w_t[RADIX_W-1:0];
            w_q   = {w_q[PAD_W-2:0], w_ge};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_rem       = r_rem;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_cnt[STORE_AW-1:0];
        w_wdata     = char_of(w_rem);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_item.is_zero) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = CH_DIGIT;
                        n_idx   = '0;
                        n_state = S_RD;
                    end else begin
                        n_q     = PAD_W'(i_item.value[NUM_WIDTH-1:0]);
                        n_rem   = '0;
                        n_step  = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_q    = w_q;
                n_rem  = w_rem;
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    w_we   = 1'b1;
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_rem  = '0;
                    n_step = '0;
                    if (w_q == '0) begin
                        n_idx   = r_cnt[STORE_AW-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || i_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_data;
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - STORE_AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_store[r_idx];
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

endmodule

>>> src/radix_digit_string_converter_core.sv
// Radix digit string converter: top level with radix register, front, queue and back.
// The back stage divides by the radix for each digit, eight bits per divider step, then reads
// the digits back from the store and loads each one into the output register.
// It takes a new item only from idle, once the last digit is loaded; two queued, one in front.
// Reset (synchronous, active low) empties all stages and sets the radix to 10.
module radix_digit_string_converter_core #(
    parameter int NUM_WIDTH = 64,
    parameter int MAX_RADIX = 86
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] digit_char, [7] zero
    output logic        m_axis_tlast
);
    import rdsc_pkg::*;

    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);

    logic [RADIX_W-1:0] r_radix;
    logic               w_cfg_ok;
    logic               w_push, w_full, w_qvalid, w_pop;
    t_item              w_front_item, w_queue_item;
    logic [CHAR_W-1:0]  w_char;

    assign w_cfg_ok = i_cfg_wen && (i_cfg_wdata >= RADIX_MIN) && (i_cfg_wdata <= RADIX_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (w_cfg_ok) begin
            r_radix <= i_cfg_wdata;
        end
    end

    rdsc_front #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_value (s_axis_tdata),
        .o_push  (w_push),
        .o_item  (w_front_item),
        .i_full  (w_full)
    );

    rdsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_item  (w_queue_item)
    );

    rdsc_back #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .o_pop    (w_pop),
        .i_item   (w_queue_item),
        .i_radix  (r_radix),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (w_char),
        .o_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_char};

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX))
        else $error("radix register out of range");

    a_bad_cfg_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_wen && ((i_cfg_wdata < RADIX_MIN) || (i_cfg_wdata > RADIX_MAX)))
        |=> (r_radix == $past(r_radix)))
        else $error("out-of-range radix write took effect");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[7] && (m_axis_tdata[6:0] >= CH_PUNCT_A)))
        else $error("digit character outside the map");

    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid)
        else $error("back stage took from an empty queue");

endmodule
